/* hw/rtl/pair_pooled_deviation_edge_conf_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pooled-deviation edge block
// Shared property forms with the block clock and reset built in.
// ----------------------------------------------------------------------------
`ifndef PAIR_POOLED_DEVIATION_EDGE_CONF_DEFINES_SVH
`define PAIR_POOLED_DEVIATION_EDGE_CONF_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPDEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pooled deviation edge: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PPDEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pooled deviation edge: next-cycle check failed");

`endif

/* hw/rtl/ppdec_pkg.sv */
// ----------------------------------------------------------------------------
// Pooled-deviation edge package
// Request and result types, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package ppdec_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BORDER_VALUE  = 2'd0,
    REG_DEV_THRESHOLD = 2'd1,
    REG_OWN_DEV_RATIO = 2'd2
  } reg_idx_e;

  localparam logic [12:0] CONF_EDGE      = 13'd100;
  localparam logic [12:0] BORDER_RESET   = 13'd8191;
  localparam logic [9:0]  RATIO_RESET    = 10'd410;
  localparam int unsigned THRESHOLD_BASE = 20;

  // One request: a neighbour pair.
  typedef struct packed {
    logic        pair_valid;
    logic [11:0] first_red;
    logic [11:0] first_green;
    logic [11:0] first_blue;
    logic [11:0] second_red;
    logic [11:0] second_green;
    logic [11:0] second_blue;
    logic [25:0] first_mean_sq_mag;
    logic [25:0] second_mean_sq_mag;
    logic [12:0] first_std_dev;
    logic [12:0] second_std_dev;
  } in_t;

  // One result.
  typedef struct packed {
    logic [12:0] gradient;
    logic [12:0] confidence;
  } out_t;

  // Data that rides along the square-root pipeline.
  typedef struct packed {
    logic        pair_valid;
    logic [12:0] first_std_dev;
    logic [12:0] second_std_dev;
  } side_t;

endpackage

/* hw/rtl/ppdec_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floors the root of a 26-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module ppdec_sqrt_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [25:0]         rad_i,
  input  ppdec_pkg::side_t    side_i,
  output logic                vld_o,
  output logic [12:0]         root_o,
  output ppdec_pkg::side_t    side_o
);

  localparam int unsigned Stages = 13;

  logic             vld_q  [Stages];
  logic [25:0]      rad_q  [Stages];
  logic [13:0]      rem_q  [Stages];
  logic [12:0]      root_q [Stages];
  ppdec_pkg::side_t side_q [Stages];

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic             vld_prev;
    logic [25:0]      rad_prev;
    logic [13:0]      rem_prev;
    logic [12:0]      root_prev;
    ppdec_pkg::side_t side_prev;
    logic [15:0]      cur;
    logic [15:0]      trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_prev  = vld_i;
      assign rad_prev  = rad_i;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign side_prev = side_i;
    end else begin : g_next
      assign vld_prev  = vld_q[i-1];
      assign rad_prev  = rad_q[i-1];
      assign rem_prev  = rem_q[i-1];
      assign root_prev = root_q[i-1];
      assign side_prev = side_q[i-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign cur   = {rem_prev, rad_prev[25:24]};
    assign trial = {1'b0, root_prev, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= {rad_prev[23:0], 2'b00};
      rem_q[i]  <= ge ? 14'(cur - trial) : cur[13:0];
      root_q[i] <= {root_prev[11:0], ge};
      side_q[i] <= side_prev;
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign root_o = root_q[Stages-1];
  assign side_o = side_q[Stages-1];

endmodule

/* hw/rtl/pair_pooled_deviation_edge_conf.sv */
// ----------------------------------------------------------------------------
// Pooled-deviation edge gradient and confidence
// Pools the statistics of a neighbour pair into a deviation and a confidence.
// ----------------------------------------------------------------------------
// A request is taken at each rising edge with start high and busy low; busy
// stays low, so one request can be taken in every cycle. Each request makes
// exactly one result on rsp_o, shown for one cycle with done_o high, after it
// passes the pipeline in order: sums, squares, variance, thirteen square-root
// stages (one root bit each), the ratio multiply and the final compare.
// Results leave in request order and cannot be held off by the receiver.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must do so only while no request is in flight, as the block does not
// enforce it. An unknown index is ignored.
// Reset empties the pipeline and loads border value 8191, threshold
// 20 << COLOR_FRAC_BITS and ratio 410 (about 0.4).
// A pair without both neighbours returns the border value in both fields.
// ----------------------------------------------------------------------------
`include "pair_pooled_deviation_edge_conf_defines.svh"

module pair_pooled_deviation_edge_conf #(
  parameter int unsigned COLOR_FRAC_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ppdec_pkg::in_t     req_i,
  output logic               done_o,
  output ppdec_pkg::out_t    rsp_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [12:0]        cfg_data_i
);

  logic [12:0] border_q, thr_q;
  logic [9:0]  ratio_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= ppdec_pkg::BORDER_RESET;
      thr_q    <= 13'(ppdec_pkg::THRESHOLD_BASE << COLOR_FRAC_BITS);
      ratio_q  <= ppdec_pkg::RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (ppdec_pkg::reg_idx_e'(cfg_idx_i))
        ppdec_pkg::REG_BORDER_VALUE:  border_q <= cfg_data_i;
        ppdec_pkg::REG_DEV_THRESHOLD: thr_q    <= cfg_data_i;
        ppdec_pkg::REG_OWN_DEV_RATIO: ratio_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic take;
  assign take = start && !busy;

  // Valid bits of the stages outside the root pipeline.
  logic p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, done_q;
  logic sq_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      p1_vld_q <= take;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= sq_vld;
      done_q   <= p4_vld_q;
    end
  end

  // Stage 1: channel sums and twice the summed mean squares.
  logic [12:0]      p1_sum_q [3];
  logic [27:0]      p1_ams_q;
  ppdec_pkg::side_t p1_side_q;
  logic [26:0]      ams_sum;
  assign ams_sum = {1'b0, req_i.first_mean_sq_mag} + {1'b0, req_i.second_mean_sq_mag};

  always_ff @(posedge clk_i) begin
    p1_sum_q[0] <= {1'b0, req_i.first_red}   + {1'b0, req_i.second_red};
    p1_sum_q[1] <= {1'b0, req_i.first_green} + {1'b0, req_i.second_green};
    p1_sum_q[2] <= {1'b0, req_i.first_blue}  + {1'b0, req_i.second_blue};
    p1_ams_q    <= {ams_sum, 1'b0};
    p1_side_q   <= '{pair_valid:     req_i.pair_valid,
                     first_std_dev:  req_i.first_std_dev,
                     second_std_dev: req_i.second_std_dev};
  end

  // Stage 2: squares of the channel sums.
  logic [25:0]      p2_sq_q [3];
  logic [27:0]      p2_ams_q;
  ppdec_pkg::side_t p2_side_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      p2_sq_q[c] <= 26'(p1_sum_q[c]) * 26'(p1_sum_q[c]);
    end
    p2_ams_q  <= p1_ams_q;
    p2_side_q <= p1_side_q;
  end

  // Stage 3: four times the pooled variance, clamped at zero, then quartered.
  logic [27:0]      sq_total;
  logic [25:0]      p3_rad_q;
  ppdec_pkg::side_t p3_side_q;
  assign sq_total = {2'b00, p2_sq_q[0]} + {2'b00, p2_sq_q[1]} + {2'b00, p2_sq_q[2]};

  always_ff @(posedge clk_i) begin
    if (p2_ams_q > sq_total) begin
      p3_rad_q <= 26'((p2_ams_q - sq_total) >> 2);
    end else begin
      p3_rad_q <= '0;
    end
    p3_side_q <= p2_side_q;
  end

  // Square root of the variance gives the gradient.
  logic [12:0]      sq_root;
  ppdec_pkg::side_t sq_side;

  ppdec_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (p3_vld_q),
    .rad_i  (p3_rad_q),
    .side_i (p3_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Stage 4: ratio limit and threshold test.
  logic [22:0]      p4_lim_q;
  logic [12:0]      p4_grad_q;
  logic             p4_low_q;
  ppdec_pkg::side_t p4_side_q;

  always_ff @(posedge clk_i) begin
    p4_lim_q  <= 23'(sq_root) * 23'(ratio_q);
    p4_grad_q <= sq_root;
    p4_low_q  <= (sq_root < thr_q);
    p4_side_q <= sq_side;
  end

  // Stage 5: own-deviation checks and the result register.
  logic            dev_high;
  ppdec_pkg::out_t rsp_q;
  logic            out_pair_q;
  assign dev_high = ({p4_side_q.first_std_dev, 10'b0} > p4_lim_q) ||
                    ({p4_side_q.second_std_dev, 10'b0} > p4_lim_q);

  always_ff @(posedge clk_i) begin
    out_pair_q <= p4_side_q.pair_valid;
    if (!p4_side_q.pair_valid) begin
      rsp_q.gradient   <= border_q;
      rsp_q.confidence <= border_q;
    end else begin
      rsp_q.gradient   <= p4_grad_q;
      rsp_q.confidence <= (p4_low_q || dev_high) ? 13'd0 : ppdec_pkg::CONF_EDGE;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A pair result only ever carries no confidence or full confidence.
  `PPDEC_ASSERT_NOW(a_conf_code, done_o && out_pair_q,
                    rsp_o.confidence == 13'd0 || rsp_o.confidence == ppdec_pkg::CONF_EDGE)
  // A taken request always enters the first stage.
  `PPDEC_ASSERT_NEXT(a_take_enters, take, p1_vld_q)

endmodule
